>>> rtl/cpid_pkg.sv
// Shared types, constants and the microcode program of the cascaded PID controller.
// Depends on nothing; every other file in rtl imports it.
package cpid_pkg;

   // Fixed field widths.
   localparam int OUT_W = 17;        // loop outputs and integral state
   localparam int FIELD_W = 16;      // one gain or one limit
   localparam int GAINS_W = 48;
   localparam int LIMITS_W = 64;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int WRAP_W = 2;
   localparam int PROD_LIMIT_LOG2 = 60;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTER_GAINS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTER_LIMITS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INNER_GAINS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INNER_LIMITS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRAP_MODE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CASCADE = 3'd5;

   // Outer error wrap modes and their moduli.
   localparam logic [WRAP_W-1:0] WRAP_NONE = 2'd0;
   localparam logic [WRAP_W-1:0] WRAP_8191 = 2'd1;
   localparam logic [WRAP_W-1:0] WRAP_DOUBLE = 2'd2;
   localparam logic [WRAP_W-1:0] WRAP_360 = 2'd3;
   localparam int WRAP_M_W = 14;
   localparam logic [WRAP_M_W-1:0] WRAP_MOD_A = 14'd8191;
   localparam logic [WRAP_M_W-1:0] WRAP_MOD_B = 14'd4095;
   localparam logic [WRAP_M_W-1:0] WRAP_MOD_C = 14'd360;

   // Control word fields.
   localparam logic LOOP_OUTER = 1'b0;
   localparam logic LOOP_INNER = 1'b1;

   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_WRAP1 = 3'd1;
   localparam logic [2:0] OP_WRAP2 = 3'd2;
   localparam logic [2:0] OP_DEAD = 3'd3;
   localparam logic [2:0] OP_INTEG = 3'd4;
   localparam logic [2:0] OP_LDE = 3'd5;
   localparam logic [2:0] OP_FIN = 3'd6;

   localparam logic [1:0] OPND_NONE = 2'd0;
   localparam logic [1:0] OPND_P = 2'd1;
   localparam logic [1:0] OPND_I = 2'd2;
   localparam logic [1:0] OPND_D = 2'd3;

   localparam logic [1:0] ACC_NONE = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_ADD_CLAMP = 2'd2;
   localparam logic [1:0] ACC_ADD = 2'd3;

   localparam logic [1:0] JMP_NEXT = 2'd0;
   localparam logic [1:0] JMP_OUT_IF_SINGLE = 2'd1;
   localparam logic [1:0] JMP_EMIT = 2'd2;

   typedef struct packed {
      logic       lp;
      logic [2:0] op;
      logic [1:0] opnd;
      logic       mul;
      logic [1:0] acc;
      logic [1:0] jmp;
   } ucode_type;

   localparam int PC_W = 5;
   localparam logic [PC_W-1:0] PC_START = 5'd0;
   localparam logic [PC_W-1:0] PC_OUT = 5'd17;

   function automatic ucode_type uword(input logic lp, input logic [2:0] op,
                                       input logic [1:0] opnd, input logic mul,
                                       input logic [1:0] acc, input logic [1:0] jmp);
      ucode_type w;
      w.lp = lp;
      w.op = op;
      w.opnd = opnd;
      w.mul = mul;
      w.acc = acc;
      w.jmp = jmp;
      return w;
   endfunction

   // Each product is registered before it is accumulated, so the accumulate
   // steps trail the multiply steps.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         5'd0: w = uword(LOOP_OUTER, OP_WRAP1, OPND_NONE, 1'b0, ACC_NONE, JMP_NEXT);
         5'd1: w = uword(LOOP_OUTER, OP_WRAP2, OPND_NONE, 1'b0, ACC_NONE, JMP_NEXT);
         5'd2: w = uword(LOOP_OUTER, OP_DEAD, OPND_NONE, 1'b0, ACC_NONE, JMP_NEXT);
         5'd3: w = uword(LOOP_OUTER, OP_INTEG, OPND_P, 1'b0, ACC_NONE, JMP_NEXT);
         5'd4: w = uword(LOOP_OUTER, OP_NONE, OPND_I, 1'b1, ACC_NONE, JMP_NEXT);
         5'd5: w = uword(LOOP_OUTER, OP_NONE, OPND_D, 1'b1, ACC_LOAD, JMP_NEXT);
         5'd6: w = uword(LOOP_OUTER, OP_NONE, OPND_NONE, 1'b1, ACC_ADD_CLAMP, JMP_NEXT);
         5'd7: w = uword(LOOP_OUTER, OP_NONE, OPND_NONE, 1'b0, ACC_ADD, JMP_NEXT);
         5'd8: w = uword(LOOP_OUTER, OP_FIN, OPND_NONE, 1'b0, ACC_NONE,
                         JMP_OUT_IF_SINGLE);
         5'd9: w = uword(LOOP_INNER, OP_LDE, OPND_NONE, 1'b0, ACC_NONE, JMP_NEXT);
         5'd10: w = uword(LOOP_INNER, OP_DEAD, OPND_NONE, 1'b0, ACC_NONE, JMP_NEXT);
         5'd11: w = uword(LOOP_INNER, OP_INTEG, OPND_P, 1'b0, ACC_NONE, JMP_NEXT);
         5'd12: w = uword(LOOP_INNER, OP_NONE, OPND_I, 1'b1, ACC_NONE, JMP_NEXT);
         5'd13: w = uword(LOOP_INNER, OP_NONE, OPND_D, 1'b1, ACC_LOAD, JMP_NEXT);
         5'd14: w = uword(LOOP_INNER, OP_NONE, OPND_NONE, 1'b1, ACC_ADD_CLAMP, JMP_NEXT);
         5'd15: w = uword(LOOP_INNER, OP_NONE, OPND_NONE, 1'b0, ACC_ADD, JMP_NEXT);
         5'd16: w = uword(LOOP_INNER, OP_FIN, OPND_NONE, 1'b0, ACC_NONE, JMP_NEXT);
         default: w = uword(LOOP_OUTER, OP_NONE, OPND_NONE, 1'b0, ACC_NONE, JMP_EMIT);
      endcase
      return w;
   endfunction

endpackage

>>> rtl/cascaded_pid_controller_unit.sv
// Top level of the cascaded PID controller: handshakes, registers and microcode sequencer.
// Depends on cpid_pkg and cpid_datapath.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  outer_target, outer_measure, inner_measure
//   rsp_      out        rsp_valid / rsp_ready  drive, outer_output
//   csr_      in         csr_wr_en              csr_index, csr_wdata
//
// An item runs through the microcode program one control word per cycle over one
// shared multiplier; the inner-loop words run only with the cascade on. The result
// waits in an output register, so the next item is taken while it is still unread;
// a new result only stalls the program at its last step while that register is
// full. Reset clears the loop state and all control registers; no clearing pass is
// needed.
module cascaded_pid_controller_unit
   import cpid_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_outer_target,
   input  logic signed [DATA_WIDTH-1:0] req_outer_measure,
   input  logic signed [DATA_WIDTH-1:0] req_inner_measure,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [OUT_W-1:0]      rsp_drive,
   output logic signed [OUT_W-1:0]      rsp_outer_output,
   input  logic                         csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   logic [GAINS_W-1:0]  outer_gains_ff, inner_gains_ff;
   logic [LIMITS_W-1:0] outer_limits_ff, inner_limits_ff;
   logic [WRAP_W-1:0]   wrap_mode_ff;
   logic                cascade_ff;

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            busy_ff, busy_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_drive_ff, rsp_outer_ff;

   ucode_type uc;
   logic      accept, out_free, emit;
   logic signed [OUT_W-1:0] dp_outer, dp_drive;

   assign uc = ucode_rom(pc_ff);
   assign req_ready = !busy_ff;
   assign accept = req_valid && !busy_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit = busy_ff && (uc.jmp == JMP_EMIT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         outer_gains_ff <= '0;
         outer_limits_ff <= '0;
         inner_gains_ff <= '0;
         inner_limits_ff <= '0;
         wrap_mode_ff <= WRAP_NONE;
         cascade_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_OUTER_GAINS: outer_gains_ff <= csr_wdata[GAINS_W-1:0];
            CSR_OUTER_LIMITS: outer_limits_ff <= csr_wdata[LIMITS_W-1:0];
            CSR_INNER_GAINS: inner_gains_ff <= csr_wdata[GAINS_W-1:0];
            CSR_INNER_LIMITS: inner_limits_ff <= csr_wdata[LIMITS_W-1:0];
            CSR_WRAP_MODE: wrap_mode_ff <= csr_wdata[WRAP_W-1:0];
            CSR_CASCADE: cascade_ff <= csr_wdata[0];
            default: cascade_ff <= cascade_ff;
         endcase
      end
   end

   // Sequencer: the idle program counter rests on the emit word, which does nothing.
   always_comb begin
      pc_in = pc_ff;
      busy_in = busy_ff;
      if (accept) begin
         pc_in = PC_START;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         case (uc.jmp)
            JMP_NEXT: pc_in = pc_ff + PC_W'(1);
            JMP_OUT_IF_SINGLE: pc_in = cascade_ff ? pc_ff + PC_W'(1) : PC_OUT;
            JMP_EMIT: busy_in = !out_free;
            default: pc_in = PC_OUT;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_OUT;
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in;
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_drive_ff <= dp_drive;
         rsp_outer_ff <= dp_outer;
      end
   end

   cpid_datapath #(
      .DATA_WIDTH(DATA_WIDTH),
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .load(accept),
      .target(req_outer_target),
      .measure(req_outer_measure),
      .inner_measure(req_inner_measure),
      .uc(uc),
      .gains((uc.lp == LOOP_INNER) ? inner_gains_ff : outer_gains_ff),
      .limits((uc.lp == LOOP_INNER) ? inner_limits_ff : outer_limits_ff),
      .wrap_mode(wrap_mode_ff),
      .outer_out(dp_outer),
      .drive(dp_drive)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;
   assign rsp_outer_output = rsp_outer_ff;

endmodule

>>> rtl/cpid_datapath.sv
// Datapath of the cascaded PID controller: error, integral, multiplier and accumulator.
// Depends on cpid_pkg; driven one control word per cycle by the top level.
module cpid_datapath
   import cpid_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic signed [DATA_WIDTH-1:0] target,
   input  logic signed [DATA_WIDTH-1:0] measure,
   input  logic signed [DATA_WIDTH-1:0] inner_measure,
   input  ucode_type                    uc,
   input  logic [GAINS_W-1:0]           gains,
   input  logic [LIMITS_W-1:0]          limits,
   input  logic [WRAP_W-1:0]            wrap_mode,
   output logic signed [OUT_W-1:0]      outer_out,
   output logic signed [OUT_W-1:0]      drive
);

   localparam int EW = ((DATA_WIDTH > OUT_W) ? DATA_WIDTH : OUT_W) + 1;
   localparam int MAG_W = EW + 1;
   localparam int PROD_W = MAG_W + FIELD_W;
   localparam int CMP_W = (PROD_W > PROD_LIMIT_LOG2 + 1) ? PROD_W : PROD_LIMIT_LOG2 + 1;
   localparam int SAT_W = (PROD_W > PROD_LIMIT_LOG2 + 1) ? PROD_LIMIT_LOG2 + 1 : PROD_W;
   localparam int ACC_W = SAT_W + 3;
   localparam int LIM_W = FIELD_W + GAIN_FRAC_BITS;
   localparam logic [CMP_W-1:0] PROD_LIMIT = CMP_W'(1) << PROD_LIMIT_LOG2;

   logic signed [EW-1:0]    e_ff, e_in;
   logic signed [DATA_WIDTH-1:0] im_ff;
   logic signed [OUT_W-1:0] integ_ff [2];
   logic signed [EW-1:0]    prev_ff [2];
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic [FIELD_W-1:0]      gain_ff, gain_in;
   logic [SAT_W-1:0]        prod_ff, prod_in;
   logic                    pneg_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [OUT_W-1:0] outer_ff, drive_ff;

   logic [FIELD_W-1:0] kp, ki, kd, dband, imax, iomax, omax;
   logic [EW-1:0]       e_abs;
   logic [WRAP_M_W-1:0] wrap_m;
   logic                wrap_on;
   logic signed [EW-1:0] wrap_ms, e_wrapped;
   logic signed [EW:0]  isum, ilim, ilim_n, iclamp;
   logic [OUT_W-1:0]    integ_abs;
   logic signed [EW:0]  dval;
   logic [EW:0]         d_abs;
   logic [PROD_W-1:0]   prod_raw;
   logic [CMP_W-1:0]    prod_ext;
   logic [LIM_W-1:0]    io_lim;
   logic [SAT_W-1:0]    add_mag;
   logic signed [ACC_W-1:0] addend, out_lim, sum_c;
   logic [ACC_W-1:0]    sum_abs;
   logic [OUT_W-1:0]    res_mag;
   logic signed [OUT_W-1:0] res;

   assign kp = gains[FIELD_W-1:0];
   assign ki = gains[2*FIELD_W-1:FIELD_W];
   assign kd = gains[3*FIELD_W-1:2*FIELD_W];
   assign dband = limits[FIELD_W-1:0];
   assign imax = limits[2*FIELD_W-1:FIELD_W];
   assign iomax = limits[3*FIELD_W-1:2*FIELD_W];
   assign omax = limits[4*FIELD_W-1:3*FIELD_W];

   assign e_abs = e_ff[EW-1] ? (~e_ff + EW'(1)) : e_ff;

   // Wrap: the second pass only acts in the double mode.
   always_comb begin
      wrap_m = WRAP_MOD_A;
      wrap_on = 1'b0;
      if (uc.op == OP_WRAP1) begin
         wrap_on = (wrap_mode != WRAP_NONE);
         wrap_m = (wrap_mode == WRAP_360) ? WRAP_MOD_C : WRAP_MOD_A;
      end else begin
         wrap_on = (wrap_mode == WRAP_DOUBLE);
         wrap_m = WRAP_MOD_B;
      end
   end

   assign wrap_ms = $signed({{(EW-WRAP_M_W){1'b0}}, wrap_m});
   assign e_wrapped = (wrap_on && (e_abs > EW'(wrap_m >> 1)))
                      ? (e_ff[EW-1] ? e_ff + wrap_ms : e_ff - wrap_ms) : e_ff;

   // Integral update with a symmetric clamp.
   assign isum = {e_ff[EW-1], e_ff}
                 + {{(EW+1-OUT_W){integ_ff[uc.lp][OUT_W-1]}}, integ_ff[uc.lp]};
   assign ilim = $signed({{(EW+1-FIELD_W){1'b0}}, imax});
   assign ilim_n = -ilim;
   assign iclamp = (isum > ilim) ? ilim : ((isum < ilim_n) ? ilim_n : isum);

   assign integ_abs = integ_ff[uc.lp][OUT_W-1] ? (~integ_ff[uc.lp] + OUT_W'(1))
                                               : integ_ff[uc.lp];
   assign dval = {e_ff[EW-1], e_ff} - {prev_ff[uc.lp][EW-1], prev_ff[uc.lp]};
   assign d_abs = dval[EW] ? (~dval + MAG_W'(1)) : dval;

   always_comb begin
      mag_in = mag_ff;
      neg_in = neg_ff;
      gain_in = gain_ff;
      case (uc.opnd)
         OPND_P: begin
            mag_in = MAG_W'(e_abs);
            neg_in = e_ff[EW-1];
            gain_in = kp;
         end
         OPND_I: begin
            mag_in = MAG_W'(integ_abs);
            neg_in = integ_ff[uc.lp][OUT_W-1];
            gain_in = ki;
         end
         OPND_D: begin
            mag_in = d_abs;
            neg_in = dval[EW];
            gain_in = kd;
         end
         default: begin
            mag_in = mag_ff;
         end
      endcase
   end

   // Magnitude product, saturated at the product limit.
   assign prod_raw = PROD_W'(gain_ff) * PROD_W'(mag_ff);
   assign prod_ext = CMP_W'(prod_raw);
   assign prod_in = (prod_ext > PROD_LIMIT) ? SAT_W'(PROD_LIMIT) : SAT_W'(prod_ext);

   // The I term is clamped on its magnitude before it joins the sum.
   assign io_lim = LIM_W'(iomax) << GAIN_FRAC_BITS;
   assign add_mag = ((uc.acc == ACC_ADD_CLAMP) && (prod_ff > SAT_W'(io_lim)))
                    ? SAT_W'(io_lim) : prod_ff;
   assign addend = pneg_ff ? -$signed(ACC_W'(add_mag)) : $signed(ACC_W'(add_mag));

   always_comb begin
      case (uc.acc)
         ACC_LOAD: acc_in = addend;
         ACC_ADD_CLAMP: acc_in = acc_ff + addend;
         ACC_ADD: acc_in = acc_ff + addend;
         default: acc_in = acc_ff;
      endcase
   end

   // Output clamp, then a shift that rounds toward zero.
   assign out_lim = $signed(ACC_W'(omax) << GAIN_FRAC_BITS);
   assign sum_c = (acc_ff > out_lim) ? out_lim : ((acc_ff < -out_lim) ? -out_lim : acc_ff);
   assign sum_abs = sum_c[ACC_W-1] ? (~sum_c + ACC_W'(1)) : sum_c;
   assign res_mag = OUT_W'(sum_abs >> GAIN_FRAC_BITS);
   assign res = sum_c[ACC_W-1] ? -$signed(res_mag) : $signed(res_mag);

   always_comb begin
      e_in = e_ff;
      if (load) begin
         e_in = {{(EW-DATA_WIDTH){target[DATA_WIDTH-1]}}, target}
                - {{(EW-DATA_WIDTH){measure[DATA_WIDTH-1]}}, measure};
      end else begin
         case (uc.op)
            OP_WRAP1: e_in = e_wrapped;
            OP_WRAP2: e_in = e_wrapped;
            OP_DEAD: e_in = (e_abs <= EW'(dband)) ? '0 : e_ff;
            OP_LDE: e_in = {{(EW-OUT_W){outer_ff[OUT_W-1]}}, outer_ff}
                           - {{(EW-DATA_WIDTH){im_ff[DATA_WIDTH-1]}}, im_ff};
            default: e_in = e_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      e_ff <= e_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      gain_ff <= gain_in;
      acc_ff <= acc_in;
      if (load) begin
         im_ff <= inner_measure;
      end
      if (uc.mul) begin
         prod_ff <= prod_in;
         pneg_ff <= neg_ff;
      end
      if (uc.op == OP_FIN) begin
         drive_ff <= res;
         if (uc.lp == LOOP_OUTER) begin
            outer_ff <= res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff[0] <= '0;
         integ_ff[1] <= '0;
         prev_ff[0] <= '0;
         prev_ff[1] <= '0;
      end else begin
         if (uc.op == OP_INTEG) begin
            integ_ff[uc.lp] <= iclamp[OUT_W-1:0];
         end
         if (uc.op == OP_FIN) begin
            prev_ff[uc.lp] <= e_ff;
         end
      end
   end

   assign outer_out = outer_ff;
   assign drive = drive_ff;

endmodule

>>> tb/sv/tb_cascaded_pid_controller_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for cascaded_pid_controller_unit: a directed stimulus table,
// then random control ticks under several register settings, checked by a local model.
// Depends on cpid_pkg and the RTL of the unit.
module tb_cascaded_pid_controller_unit
   import cpid_pkg::*;
();

   localparam int DATA_W = 32;
   localparam int GAIN_FRAC = 8;
   localparam longint PROD_SAT = 64'sd1 << PROD_LIMIT_LOG2;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 50;

   // Indexes outside the register map; writes to them must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_INDEX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]    data;
      logic signed [DATA_W-1:0] tgt;
      logic signed [DATA_W-1:0] om;
      logic signed [DATA_W-1:0] im;
      logic                     typed;
      logic signed [OUT_W-1:0]  drive;
      logic signed [OUT_W-1:0]  outer_out;
   } stim_row_type;

   typedef struct {
      logic signed [OUT_W-1:0] drive;
      logic signed [OUT_W-1:0] outer_out;
   } drive_cmd_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_outer_target = '0;
   logic signed [DATA_W-1:0] req_outer_measure = '0;
   logic signed [DATA_W-1:0] req_inner_measure = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [OUT_W-1:0]  rsp_drive;
   logic signed [OUT_W-1:0]  rsp_outer_output;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   // Local copy of the registers and loop state, indexed by LOOP_OUTER / LOOP_INNER.
   logic [GAINS_W-1:0]  loop_gains [2];
   logic [LIMITS_W-1:0] loop_limits [2];
   longint              loop_integ [2];
   longint              loop_prev [2];
   logic [WRAP_W-1:0]   wrap_sel;
   logic                cascade_on;

   drive_cmd_type awaited_cmds [$];
   drive_cmd_type got_cmd;
   stim_row_type  stim_rows [$];
   int            fail_count = 0;
   int            sender_idle_pct = 16;
   int            rsp_idle_pct = 16;
   logic          hold_off_req = 1'b0;
   int            hold_left = 0;
   bit            req_raised = 1'b0;

   cascaded_pid_controller_unit #(
      .DATA_WIDTH(DATA_W),
      .GAIN_FRAC_BITS(GAIN_FRAC)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_outer_target(req_outer_target),
      .req_outer_measure(req_outer_measure),
      .req_inner_measure(req_inner_measure),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_drive(rsp_drive),
      .rsp_outer_output(rsp_outer_output),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("cascaded_pid_controller_unit regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic longint limit_sym(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint gain_product(input logic [15:0] gain, input longint x);
      longint g, mag, p;
      g = longint'(gain);
      mag = (x < 0) ? -x : x;
      if (g != 0 && mag > PROD_SAT / g) p = PROD_SAT;
      else p = mag * g;
      return (x < 0) ? -p : p;
   endfunction

   function automatic longint wrap_error(input longint e, input longint m);
      longint mag;
      mag = (e < 0) ? -e : e;
      if (2 * mag > m) return (e >= 0) ? e - m : e + m;
      return e;
   endfunction

   function automatic longint pid_stage(input logic lp, input longint err_in);
      longint err, dead, imax, iomax, omax, mag, pt, it, dt, sum;
      err = err_in;
      dead = longint'(loop_limits[lp][15:0]);
      imax = longint'(loop_limits[lp][31:16]);
      iomax = longint'(loop_limits[lp][47:32]) << GAIN_FRAC;
      omax = longint'(loop_limits[lp][63:48]) << GAIN_FRAC;
      mag = (err < 0) ? -err : err;
      if (mag <= dead) err = 0;
      loop_integ[lp] = limit_sym(loop_integ[lp] + err, imax);
      pt = gain_product(loop_gains[lp][15:0], err);
      it = limit_sym(gain_product(loop_gains[lp][31:16], loop_integ[lp]), iomax);
      dt = gain_product(loop_gains[lp][47:32], err - loop_prev[lp]);
      sum = limit_sym(pt + it + dt, omax);
      loop_prev[lp] = err;
      // The loop output is truncated toward zero, not floored.
      return (sum >= 0) ? (sum >>> GAIN_FRAC) : -((-sum) >>> GAIN_FRAC);
   endfunction

   function automatic drive_cmd_type control_tick(input logic signed [DATA_W-1:0] tgt,
                                                  input logic signed [DATA_W-1:0] om,
                                                  input logic signed [DATA_W-1:0] im);
      drive_cmd_type cmd;
      longint err, oo, dv;
      err = longint'(tgt) - longint'(om);
      case (wrap_sel)
         WRAP_8191: err = wrap_error(err, WRAP_MOD_A);
         WRAP_DOUBLE: err = wrap_error(wrap_error(err, WRAP_MOD_A), WRAP_MOD_B);
         WRAP_360: err = wrap_error(err, WRAP_MOD_C);
         default: ;
      endcase
      oo = pid_stage(LOOP_OUTER, err);
      dv = oo;
      if (cascade_on) dv = pid_stage(LOOP_INNER, oo - longint'(im));
      cmd.drive = dv[OUT_W-1:0];
      cmd.outer_out = oo[OUT_W-1:0];
      return cmd;
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_OUTER_GAINS: loop_gains[LOOP_OUTER] = data[GAINS_W-1:0];
         CSR_OUTER_LIMITS: loop_limits[LOOP_OUTER] = data[LIMITS_W-1:0];
         CSR_INNER_GAINS: loop_gains[LOOP_INNER] = data[GAINS_W-1:0];
         CSR_INNER_LIMITS: loop_limits[LOOP_INNER] = data[LIMITS_W-1:0];
         CSR_WRAP_MODE: wrap_sel = data[WRAP_W-1:0];
         CSR_CASCADE: cascade_on = data[0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic logic [CSR_DATA_W-1:0] gains_word(input logic [15:0] kp,
                                                        input logic [15:0] ki,
                                                        input logic [15:0] kd);
      return {16'h0000, kd, ki, kp};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] limits_word(input logic [15:0] db,
                                                         input logic [15:0] imax,
                                                         input logic [15:0] iomax,
                                                         input logic [15:0] omax);
      return {omax, iomax, imax, db};
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] data);
      stim_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.idx = idx;
      r.data = data;
      return r;
   endfunction

   function automatic stim_row_type item_row(input logic signed [DATA_W-1:0] tgt,
                                             input logic signed [DATA_W-1:0] om,
                                             input logic signed [DATA_W-1:0] im);
      stim_row_type r;
      r = '0;
      r.kind = ROW_ITEM;
      r.tgt = tgt;
      r.om = om;
      r.im = im;
      return r;
   endfunction

   function automatic stim_row_type check_row(input logic signed [DATA_W-1:0] tgt,
                                              input logic signed [DATA_W-1:0] om,
                                              input logic signed [DATA_W-1:0] im,
                                              input logic signed [OUT_W-1:0] drive,
                                              input logic signed [OUT_W-1:0] outer_out);
      stim_row_type r;
      r = item_row(tgt, om, im);
      r.typed = 1'b1;
      r.drive = drive;
      r.outer_out = outer_out;
      return r;
   endfunction

   function automatic logic [15:0] pick_field(input int phase);
      if (phase == 0) return 16'hFFFF;
      if (phase == 1) return 16'h0000;
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2, 3, 4, 5: return 16'($urandom_range(16'h0300));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] sample_word();
      case ($urandom_range(9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2, 3: return $urandom;
         default: return int'($urandom_range(20000)) - 10000;
      endcase
   endfunction

   // Lowers valid at most once per step, so a following raise never shares a step with it.
   task automatic release_req();
      if (req_raised) begin
         req_valid <= 1'b0;
         req_raised = 1'b0;
      end
   endtask

   task automatic await_drain();
      release_req();
      while (awaited_cmds.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      apply_csr(idx, data);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_item(input logic signed [DATA_W-1:0] tgt,
                            input logic signed [DATA_W-1:0] om,
                            input logic signed [DATA_W-1:0] im,
                            input logic typed,
                            input logic signed [OUT_W-1:0] drive,
                            input logic signed [OUT_W-1:0] outer_out);
      drive_cmd_type cmd;
      if ($urandom_range(99) < sender_idle_pct) begin
         release_req();
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raised = 1'b1;
      req_outer_target <= tgt;
      req_outer_measure <= om;
      req_inner_measure <= im;
      do @(posedge clock); while (!req_ready);
      cmd = control_tick(tgt, om, im);
      if (typed) begin
         cmd.drive = drive;
         cmd.outer_out = outer_out;
      end
      awaited_cmds.push_back(cmd);
   endtask

   // ---------------------------------------------------------------- receiver and checker

   always @(posedge clock) begin
      if (hold_off_req) begin
         hold_off_req <= 1'b0;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_cmds.size() == 0) begin
            $display("%0t ns: drive command with none awaited: drive %0d outer %0d",
                     $time, rsp_drive, rsp_outer_output);
            fail_count++;
         end else begin
            got_cmd = awaited_cmds.pop_front();
            if (rsp_drive !== got_cmd.drive) begin
               $display("%0t ns: drive expected %0d actual %0d",
                        $time, got_cmd.drive, rsp_drive);
               fail_count++;
            end
            if (rsp_outer_output !== got_cmd.outer_out) begin
               $display("%0t ns: outer_output expected %0d actual %0d",
                        $time, got_cmd.outer_out, rsp_outer_output);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      stim_row_type             row;
      logic [CSR_INDEX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]    data;
      logic signed [DATA_W-1:0] tgt;
      logic signed [DATA_W-1:0] om;

      for (int lp = 0; lp < 2; lp++) begin
         loop_gains[lp] = '0;
         loop_limits[lp] = '0;
         loop_integ[lp] = 0;
         loop_prev[lp] = 0;
      end
      wrap_sel = WRAP_NONE;
      cascade_on = 1'b0;

      // With every register at zero the output limit forces both outputs to zero.
      stim_rows.push_back(check_row(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0));
      stim_rows.push_back(check_row(-1, 1, 32'sh7FFF_FFFF, 0, 0));
      // Unity proportional gain, deadband of 10; upper value bits must be dropped.
      stim_rows.push_back(csr_row(CSR_OUTER_GAINS,
                                  64'hDEAD_0000_0000_0000 | gains_word(16'h0100, 0, 0)));
      stim_rows.push_back(csr_row(CSR_OUTER_LIMITS, limits_word(10, 0, 0, 16'hFFFF)));
      stim_rows.push_back(csr_row(CSR_SPARE_A, '1));
      stim_rows.push_back(csr_row(CSR_SPARE_B, '1));
      stim_rows.push_back(check_row(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 65535, 65535));
      stim_rows.push_back(check_row(32'sh8000_0000, 32'sh7FFF_FFFF, 0, -65535, -65535));
      stim_rows.push_back(check_row(10, 0, 0, 0, 0));
      stim_rows.push_back(check_row(11, 0, 0, 11, 11));
      stim_rows.push_back(check_row(-10, 0, 0, 0, 0));
      stim_rows.push_back(check_row(0, 11, 0, -11, -11));
      // Only the low two bits select the wrap, here the 360 one.
      stim_rows.push_back(csr_row(CSR_WRAP_MODE, 64'hFFFF_FFFF_FFFF_FFF7));
      stim_rows.push_back(check_row(181, 0, 0, -179, -179));
      stim_rows.push_back(check_row(0, 181, 0, 179, 179));
      stim_rows.push_back(check_row(180, 0, 0, 180, 180));
      stim_rows.push_back(csr_row(CSR_WRAP_MODE, 64'(WRAP_8191)));
      stim_rows.push_back(check_row(4096, 0, 0, -4095, -4095));
      stim_rows.push_back(check_row(4095, 0, 0, 4095, 4095));
      stim_rows.push_back(csr_row(CSR_WRAP_MODE, 64'(WRAP_DOUBLE)));
      stim_rows.push_back(check_row(8000, 0, 0, -191, -191));
      stim_rows.push_back(check_row(6000, 0, 0, 1904, 1904));
      // Half gain with no deadband shows truncation toward zero on both signs.
      stim_rows.push_back(csr_row(CSR_WRAP_MODE, 64'(WRAP_NONE)));
      stim_rows.push_back(csr_row(CSR_OUTER_GAINS, gains_word(16'h0080, 0, 0)));
      stim_rows.push_back(csr_row(CSR_OUTER_LIMITS, limits_word(0, 0, 0, 16'hFFFF)));
      stim_rows.push_back(check_row(3, 0, 0, 1, 1));
      stim_rows.push_back(check_row(0, 3, 0, -1, -1));
      // Cascade on: the inner loop follows the integer outer output.
      stim_rows.push_back(csr_row(CSR_OUTER_GAINS, gains_word(16'h0100, 0, 0)));
      stim_rows.push_back(csr_row(CSR_INNER_GAINS, gains_word(16'h0100, 0, 0)));
      stim_rows.push_back(csr_row(CSR_INNER_LIMITS, limits_word(0, 0, 0, 16'hFFFF)));
      stim_rows.push_back(csr_row(CSR_CASCADE, 64'h8000_0000_0000_0001));
      stim_rows.push_back(check_row(100, 0, 30, 70, 100));
      stim_rows.push_back(check_row(100, 0, -65535, 65535, 100));
      // Full PID on both loops with integral and term limits in play.
      stim_rows.push_back(csr_row(CSR_OUTER_GAINS, gains_word(16'h0180, 16'h0040, 16'h0200)));
      stim_rows.push_back(csr_row(CSR_OUTER_LIMITS, limits_word(2, 500, 300, 2000)));
      stim_rows.push_back(csr_row(CSR_INNER_GAINS, gains_word(16'h0100, 16'h0020, 16'h0080)));
      stim_rows.push_back(csr_row(CSR_INNER_LIMITS, limits_word(1, 1000, 100, 30000)));
      stim_rows.push_back(item_row(50, 0, 5));
      stim_rows.push_back(item_row(50, 10, -7));
      stim_rows.push_back(item_row(-300, 20, 100));
      stim_rows.push_back(item_row(1000, -1000, 0));
      stim_rows.push_back(item_row(0, 0, 0));
      // Cascade off: the inner measurement is ignored and the inner state held.
      stim_rows.push_back(csr_row(CSR_CASCADE, 64'hFFFF_FFFF_FFFF_FFFE));
      stim_rows.push_back(item_row(0, 0, 12345));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[k]) begin
         row = stim_rows[k];
         if (row.kind == ROW_CSR) begin
            await_drain();
            csr_write(row.idx, row.data);
         end else begin
            send_item(row.tgt, row.om, row.im, row.typed, row.drive, row.outer_out);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         await_drain();
         // Every index is rewritten; all but the limits get junk in their upper bits.
         for (int r = 0; r < 8; r++) begin
            idx = r[CSR_INDEX_W-1:0];
            data = {$urandom, $urandom};
            case (idx)
               CSR_OUTER_GAINS, CSR_INNER_GAINS:
                  data[GAINS_W-1:0] = {pick_field(phase), pick_field(phase), pick_field(phase)};
               CSR_OUTER_LIMITS, CSR_INNER_LIMITS:
                  data = {pick_field(phase), pick_field(phase), pick_field(phase),
                          pick_field(phase)};
               CSR_WRAP_MODE:
                  data[WRAP_W-1:0] = (phase == 0) ? WRAP_360 : WRAP_W'($urandom_range(3));
               CSR_CASCADE:
                  data[0] = (phase == 0) ? 1'b1 : 1'($urandom_range(1));
               default: ;
            endcase
            csr_write(idx, data);
         end

         sender_idle_pct = (phase == 3) ? 0 : 16;
         rsp_idle_pct = (phase == 3) ? 0 : 16;
         if (phase == 5) hold_off_req <= 1'b1;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 6 && n == PHASE_ITEMS / 2) await_drain();
            tgt = sample_word();
            if ($urandom_range(3) == 0) om = sample_word();
            else om = tgt - (int'($urandom_range(18000)) - 9000);
            send_item(tgt, om, sample_word(), 1'b0, '0, '0);
         end
      end

      await_drain();
      repeat (30) @(posedge clock);
      if (fail_count == 0) begin
         $display("cascaded_pid_controller_unit regression: pass");
      end else begin
         $display("cascaded_pid_controller_unit regression: fail");
      end
      $finish;
   end

endmodule

>>> cascaded_pid_controller_unit.f
rtl/cpid_pkg.sv
rtl/cpid_datapath.sv
rtl/cascaded_pid_controller_unit.sv
tb/sv/tb_cascaded_pid_controller_unit.sv
